@@ rtl/gwd_pkg.sv @@
// shared types, constants and helpers of the grid warp dispatcher
package gwd_pkg;

	// default parameter values
	localparam int          MAX_WARP_LANES_DEF = 32;
	localparam int          WARP_ID_BITS_DEF   = 10;
	localparam int          BLOCK_ID_BITS_DEF  = 16;
	localparam logic [32:0] MEMORY_BYTES_DEF   = 33'd67108864;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_X  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_Y  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_Z  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_X = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_Y = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_Z = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_LANES   = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_PC      = 3'd7;

	// result status codes, in check priority order
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DISABLED  = 3'd1,
		ST_BAD_PC    = 3'd2,
		ST_ZERO_DIM  = 3'd3,
		ST_BAD_WARP  = 3'd4,
		ST_THREADS   = 3'd5,
		ST_WARPS     = 3'd6,
		ST_BLOCKS    = 3'd7
	} status_code_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK1,
		S_CHK2,
		S_CHK3,
		S_FIRST,
		S_RUN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic         mul_en;
		logic         launch;
		logic         issue;
		logic         load_err;
		status_code_t err_code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		status_code_t check_code;
		logic         issue_last;
		logic         slot_free;
	} stat_t;

	// bit position of a one-hot warp width
	function automatic logic [2:0] lane_shift(input logic [7:0] w);
		logic [2:0] sh;
		sh = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (w[i]) begin
				sh = 3'(i);
			end
		end
		return sh;
	endfunction

endpackage

@@ rtl/grid_warp_dispatcher.sv @@
// grid warp dispatcher: checks a kernel launch and hands out warps block by block
// sequence: a disabled request loads its error on acceptance; else two multiply stages and
//   one evaluate state load a check error or launch; first warp issue waits for a free slot
// throughput: one warp per cycle in a running launch, while requests arrive and a slot is free
// reset: arst_n clears the launch and result valid; config registers take their defaults
module grid_warp_dispatcher #(
	parameter int          MAX_WARP_LANES = gwd_pkg::MAX_WARP_LANES_DEF,
	parameter int          WARP_ID_BITS   = gwd_pkg::WARP_ID_BITS_DEF,
	parameter int          BLOCK_ID_BITS  = gwd_pkg::BLOCK_ID_BITS_DEF,
	parameter logic [32:0] MEMORY_BYTES   = gwd_pkg::MEMORY_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [gwd_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             device_enabled,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       status,
	output logic [15:0]                      block_coord_x,
	output logic [15:0]                      block_coord_y,
	output logic [15:0]                      block_coord_z,
	output logic [15:0]                      block_number,
	output logic [9:0]                       warp_number,
	output logic [31:0]                      first_thread,
	output logic [31:0]                      active_lanes,
	output logic [31:0]                      warp_pc,
	output logic                             last_warp
);

	gwd_pkg::cmd_t  cmd;
	gwd_pkg::stat_t st;

	// sequencer
	gwd_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.device_enabled (device_enabled),
		.st             (st),
		.cmd            (cmd)
	);

	// datapath
	gwd_datapath #(
		.MAX_WARP_LANES (MAX_WARP_LANES),
		.WARP_ID_BITS   (WARP_ID_BITS),
		.BLOCK_ID_BITS  (BLOCK_ID_BITS),
		.MEMORY_BYTES   (MEMORY_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.st            (st),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.block_coord_x (block_coord_x),
		.block_coord_y (block_coord_y),
		.block_coord_z (block_coord_z),
		.block_number  (block_number),
		.warp_number   (warp_number),
		.first_thread  (first_thread),
		.active_lanes  (active_lanes),
		.warp_pc       (warp_pc),
		.last_warp     (last_warp)
	);

	// a result is only written into a free slot
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue || cmd.load_err) |-> st.slot_free)
		else $error("result written over an untaken transaction");

	// issue and error never load together
	a_load_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.issue && cmd.load_err))
		else $error("warp issue and error load in the same cycle");

	// an error load shows up as a last, non-ok result
	a_err_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_err |=> (out_valid && last_warp && status != gwd_pkg::ST_OK))
		else $error("error result not presented as final");

	// a launch is followed by its first warp issue before any new request
	a_launch_issue: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.launch |=> !in_ready)
		else $error("request taken before first warp of launch");

endmodule

@@ rtl/gwd_ctrl.sv @@
// launch sequencer: check steps, first warp and warp issue per request
module gwd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          device_enabled,
	input  gwd_pkg::stat_t st,
	output gwd_pkg::cmd_t  cmd
);

	gwd_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gwd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.mul_en   = 1'b0;
		cmd.launch   = 1'b0;
		cmd.issue    = 1'b0;
		cmd.load_err = 1'b0;
		cmd.err_code = gwd_pkg::ST_OK;
		unique case (state_q)
			gwd_pkg::S_IDLE: begin
				in_ready = st.slot_free;
				if (in_valid && st.slot_free) begin
					if (!device_enabled) begin
						cmd.load_err = 1'b1;
						cmd.err_code = gwd_pkg::ST_DISABLED;
					end else begin
						state_d = gwd_pkg::S_CHK1;
					end
				end
			end
			gwd_pkg::S_CHK1: begin
				cmd.mul_en = 1'b1;
				state_d    = gwd_pkg::S_CHK2;
			end
			gwd_pkg::S_CHK2: begin
				cmd.mul_en = 1'b1;
				state_d    = gwd_pkg::S_CHK3;
			end
			gwd_pkg::S_CHK3: begin
				if (st.check_code != gwd_pkg::ST_OK) begin
					cmd.load_err = 1'b1;
					cmd.err_code = st.check_code;
					state_d      = gwd_pkg::S_IDLE;
				end else begin
					cmd.launch = 1'b1;
					state_d    = gwd_pkg::S_FIRST;
				end
			end
			gwd_pkg::S_FIRST: begin
				// the starting request is already taken, issue its warp
				if (st.slot_free) begin
					cmd.issue = 1'b1;
					state_d   = st.issue_last ? gwd_pkg::S_IDLE : gwd_pkg::S_RUN;
				end
			end
			gwd_pkg::S_RUN: begin
				in_ready = st.slot_free;
				if (in_valid && st.slot_free) begin
					cmd.issue = 1'b1;
					if (st.issue_last) begin
						state_d = gwd_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = gwd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/gwd_datapath.sv @@
// configuration registers, launch check, grid walk counters and result register
module gwd_datapath #(
	parameter int          MAX_WARP_LANES = gwd_pkg::MAX_WARP_LANES_DEF,
	parameter int          WARP_ID_BITS   = gwd_pkg::WARP_ID_BITS_DEF,
	parameter int          BLOCK_ID_BITS  = gwd_pkg::BLOCK_ID_BITS_DEF,
	parameter logic [32:0] MEMORY_BYTES   = gwd_pkg::MEMORY_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gwd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [31:0]                       cfg_data,
	input  gwd_pkg::cmd_t                     cmd,
	output gwd_pkg::stat_t                    st,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        status,
	output logic [15:0]                       block_coord_x,
	output logic [15:0]                       block_coord_y,
	output logic [15:0]                       block_coord_z,
	output logic [15:0]                       block_number,
	output logic [9:0]                        warp_number,
	output logic [31:0]                       first_thread,
	output logic [31:0]                       active_lanes,
	output logic [31:0]                       warp_pc,
	output logic                              last_warp
);

	// counters at least as wide as the result fields they feed
	localparam int WW = (WARP_ID_BITS > 10) ? WARP_ID_BITS : 10;
	localparam int LW = (BLOCK_ID_BITS > 16) ? BLOCK_ID_BITS : 16;

	logic [15:0] grid_x_q, grid_y_q, grid_z_q;
	logic [15:0] blk_x_q, blk_y_q, blk_z_q;
	logic [7:0]  lanes_q;
	logic [31:0] pc_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= 16'd1;
			grid_y_q <= 16'd1;
			grid_z_q <= 16'd1;
			blk_x_q  <= 16'd1;
			blk_y_q  <= 16'd1;
			blk_z_q  <= 16'd1;
			lanes_q  <= 8'd32;
			pc_q     <= 32'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				gwd_pkg::REG_GRID_X:  grid_x_q <= cfg_data[15:0];
				gwd_pkg::REG_GRID_Y:  grid_y_q <= cfg_data[15:0];
				gwd_pkg::REG_GRID_Z:  grid_z_q <= cfg_data[15:0];
				gwd_pkg::REG_BLOCK_X: blk_x_q  <= cfg_data[15:0];
				gwd_pkg::REG_BLOCK_Y: blk_y_q  <= cfg_data[15:0];
				gwd_pkg::REG_BLOCK_Z: blk_z_q  <= cfg_data[15:0];
				gwd_pkg::REG_LANES:   lanes_q  <= cfg_data[7:0];
				gwd_pkg::REG_PC:      pc_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// size products, one multiply per stage
	logic [31:0] blk_prod_q, grid_prod_q;
	logic [47:0] threads_q, blocks_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			blk_prod_q  <= blk_x_q * blk_y_q;
			grid_prod_q <= grid_x_q * grid_y_q;
			threads_q   <= blk_prod_q * blk_z_q;
			blocks_q    <= grid_prod_q * grid_z_q;
		end
	end

	// launch check
	logic                  pc_bad, dim_zero, lanes_bad;
	logic [32:0]           warp_sum, warps_pb;
	gwd_pkg::status_code_t check_code;

	always_comb begin
		pc_bad    = {1'b0, pc_q} >= MEMORY_BYTES;
		dim_zero  = (grid_x_q == 16'd0) || (grid_y_q == 16'd0) || (grid_z_q == 16'd0) ||
		            (blk_x_q == 16'd0) || (blk_y_q == 16'd0) || (blk_z_q == 16'd0);
		lanes_bad = (lanes_q == 8'd0) || (lanes_q > 8'(MAX_WARP_LANES)) ||
		            ((lanes_q & (lanes_q - 8'd1)) != 8'd0);
		warp_sum  = {1'b0, threads_q[31:0]} + {25'd0, lanes_q} - 33'd1;
		warps_pb  = warp_sum >> gwd_pkg::lane_shift(lanes_q);
		if (pc_bad) begin
			check_code = gwd_pkg::ST_BAD_PC;
		end else if (dim_zero) begin
			check_code = gwd_pkg::ST_ZERO_DIM;
		end else if (lanes_bad) begin
			check_code = gwd_pkg::ST_BAD_WARP;
		end else if (threads_q[47:32] != 16'd0) begin
			check_code = gwd_pkg::ST_THREADS;
		end else if (warps_pb > (33'd1 << WARP_ID_BITS)) begin
			check_code = gwd_pkg::ST_WARPS;
		end else if (blocks_q > (48'd1 << BLOCK_ID_BITS)) begin
			check_code = gwd_pkg::ST_BLOCKS;
		end else begin
			check_code = gwd_pkg::ST_OK;
		end
	end

	// launch snapshot and walk state
	logic [15:0]   run_gx_q, run_gy_q, run_gz_q;
	logic [7:0]    run_lanes_q;
	logic [31:0]   run_pc_q, tpb_q, base_q, rem_q;
	logic [WW-1:0] warp_q, warp_last_q;
	logic [LW-1:0] lin_q;
	logic [15:0]   x_q, y_q, z_q;

	logic        warp_end, x_end, y_end, z_end, walk_last;
	logic [7:0]  n_active;
	logic [31:0] mask;

	always_comb begin
		warp_end  = warp_q == warp_last_q;
		x_end     = ({1'b0, x_q} + 17'd1) == {1'b0, run_gx_q};
		y_end     = ({1'b0, y_q} + 17'd1) == {1'b0, run_gy_q};
		z_end     = ({1'b0, z_q} + 17'd1) == {1'b0, run_gz_q};
		walk_last = warp_end && x_end && y_end && z_end;
		n_active  = (rem_q < {24'd0, run_lanes_q}) ? rem_q[7:0] : run_lanes_q;
		mask      = (n_active >= 8'd32) ? '1 : 32'((33'd1 << n_active) - 33'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_gx_q    <= 16'd0;
			run_gy_q    <= 16'd0;
			run_gz_q    <= 16'd0;
			run_lanes_q <= 8'd0;
			run_pc_q    <= 32'd0;
			tpb_q       <= 32'd0;
			warp_last_q <= '0;
			warp_q      <= '0;
			lin_q       <= '0;
			base_q      <= 32'd0;
			rem_q       <= 32'd0;
			x_q         <= 16'd0;
			y_q         <= 16'd0;
			z_q         <= 16'd0;
		end else if (cmd.launch) begin
			run_gx_q    <= grid_x_q;
			run_gy_q    <= grid_y_q;
			run_gz_q    <= grid_z_q;
			run_lanes_q <= lanes_q;
			run_pc_q    <= pc_q;
			tpb_q       <= threads_q[31:0];
			warp_last_q <= WW'(warps_pb - 33'd1);
			warp_q      <= '0;
			lin_q       <= '0;
			base_q      <= 32'd0;
			rem_q       <= threads_q[31:0];
			x_q         <= 16'd0;
			y_q         <= 16'd0;
			z_q         <= 16'd0;
		end else if (cmd.issue) begin
			// next warp, or next block with x fastest
			if (!warp_end) begin
				warp_q <= warp_q + WW'(1);
				base_q <= base_q + {24'd0, run_lanes_q};
				rem_q  <= rem_q - {24'd0, run_lanes_q};
			end else begin
				warp_q <= '0;
				base_q <= 32'd0;
				rem_q  <= tpb_q;
				// linear block number restarts after the final block
				lin_q  <= walk_last ? '0 : lin_q + LW'(1);
				if (!x_end) begin
					x_q <= x_q + 16'd1;
				end else begin
					x_q <= 16'd0;
					if (!y_end) begin
						y_q <= y_q + 16'd1;
					end else begin
						y_q <= 16'd0;
						if (!z_end) begin
							z_q <= z_q + 16'd1;
						end else begin
							z_q <= 16'd0;
						end
					end
				end
			end
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.issue || cmd.load_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			status        <= gwd_pkg::ST_OK;
			block_coord_x <= x_q;
			block_coord_y <= y_q;
			block_coord_z <= z_q;
			block_number  <= lin_q[15:0];
			warp_number   <= warp_q[9:0];
			first_thread  <= base_q;
			active_lanes  <= mask;
			warp_pc       <= run_pc_q;
			last_warp     <= walk_last;
		end else if (cmd.load_err) begin
			status        <= cmd.err_code;
			block_coord_x <= 16'd0;
			block_coord_y <= 16'd0;
			block_coord_z <= 16'd0;
			block_number  <= 16'd0;
			warp_number   <= 10'd0;
			first_thread  <= 32'd0;
			active_lanes  <= 32'd0;
			warp_pc       <= 32'd0;
			last_warp     <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign st.check_code = check_code;
	assign st.issue_last = walk_last;
	assign st.slot_free  = !out_valid_q || out_ready;

endmodule
